[design/soc_pkg.sv]
// Package for the substring occurrence counter: request and result payload
// types, cell control struct, operation codes and register map constants.
// No dependencies.
package soc_pkg;

  localparam int unsigned LEN_W   = 7;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

  // Operation codes carried in a request.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] pattern_index;
    logic [7:0]         data_byte;
    logic               end_of_text;
  } req_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] match_count;
    logic               final_res;
  } res_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       rot_up;
    logic       rot_dn;
    logic [7:0] data_byte;
  } cell_ctl_t;

endpackage

[design/soc_cfg.sv]
// APB-style configuration register block holding pattern_length.
// Depends on soc_pkg.
module soc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [soc_pkg::PADDR_W-1:0]  paddr,
  input  logic [soc_pkg::PDATA_W-1:0]  pwdata,
  output logic [soc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [soc_pkg::LEN_W-1:0]    len_o
);

  logic [soc_pkg::LEN_W-1:0] len_q, len_d;
  logic                      sel_len;

  assign pready  = 1'b1;
  assign sel_len = (paddr[2] == soc_pkg::REG_PATTERN_LENGTH);

  always_comb begin
    len_d = len_q;
    if (psel && penable && pwrite && pready && sel_len) begin
      len_d = pwdata[soc_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= soc_pkg::LEN_RESET;
    end else begin
      len_q <= len_d;
    end
  end

  assign prdata = sel_len ? soc_pkg::PDATA_W'(len_q) : '0;
  assign len_o  = len_q;

endmodule

[design/soc_cell.sv]
// One cell of the matching chain: a history byte with its valid bit and one
// pattern byte, both handed to neighbors. Depends on soc_pkg.
module soc_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  soc_pkg::cell_ctl_t    ctl_i,
  input  logic                  load_i,
  input  logic [7:0]            hist_i,
  input  logic                  valid_i,
  input  logic [7:0]            pat_lo_i,
  input  logic [7:0]            pat_hi_i,
  input  logic [LW-1:0]         len_i,
  output logic [7:0]            hist_o,
  output logic                  valid_o,
  output logic [7:0]            pat_o,
  output logic                  ok_o
);

  localparam logic [LW-1:0] IDX_W = LW'(IDX);

  logic [7:0] hist_q, hist_d;
  logic [7:0] pat_q, pat_d;
  logic       valid_q, valid_d;

  always_comb begin
    hist_d  = hist_q;
    valid_d = valid_q;
    pat_d   = pat_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      hist_d  = hist_i;
      valid_d = valid_i;
    end
    priority if (load_i) begin
      pat_d = ctl_i.data_byte;
    end else if (ctl_i.rot_up) begin
      pat_d = pat_lo_i;
    end else if (ctl_i.rot_dn) begin
      pat_d = pat_hi_i;
    end else begin
      pat_d = pat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    pat_q  <= pat_d;
  end

  // Positions outside the active pattern window always agree.
  assign ok_o    = (IDX_W >= len_i) || (valid_q && (hist_q == pat_q));
  assign hist_o  = hist_q;
  assign valid_o = valid_q;
  assign pat_o   = pat_q;

endmodule

[design/substring_occurrence_counter_top.sv]
// A text request is shifted into the history when accepted, then compared in all
// cells; its result is registered once the output register is free. No new request
// is taken while a judgment is pending; a pattern load gives no result.
// After a pattern_length write the pattern row rotates one cell per cycle, with
// requests stalled, up to the new length. Reset (rst_ni low, asynchronous)
// clears history, count and result; pattern bytes stay undefined until loaded.
module substring_occurrence_counter_top #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  soc_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output soc_pkg::res_t                out_res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [soc_pkg::PADDR_W-1:0]  paddr,
  input  logic [soc_pkg::PDATA_W-1:0]  pwdata,
  output logic [soc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  // LW holds a length 0..PATTERN_MAX. EW is wide enough to compare it with the
  // 7-bit register, SW to form a cell index sum without wrapping.
  localparam int unsigned LW  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned EW  = (LW > soc_pkg::LEN_W) ? LW : soc_pkg::LEN_W;
  localparam int unsigned SW0 = LW + 2;
  localparam int unsigned SW  = (SW0 > soc_pkg::INDEX_W + 1) ? SW0 : soc_pkg::INDEX_W + 1;

  // Configuration register.
  logic [soc_pkg::LEN_W-1:0] cfg_len;

  soc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len_o   (cfg_len)
  );

  // The effective length is the register clamped to the chain length.
  logic [EW-1:0] len_ext;
  logic [LW-1:0] len_tgt;

  assign len_ext = EW'(cfg_len);
  assign len_tgt = (len_ext > EW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_ext);

  // Cell j holds pattern byte (len_cur - 1 - j) mod PATTERN_MAX, so that it
  // lines up with history byte j. When the length changes, the pattern row
  // rotates one position per cycle until len_cur reaches the new length.
  logic [LW-1:0] len_cur_q, len_cur_d;
  logic          align_busy;
  logic          rot_up, rot_dn;

  assign align_busy = (len_cur_q != len_tgt);
  assign rot_up     = align_busy && (len_cur_q < len_tgt);
  assign rot_dn     = align_busy && !rot_up;

  always_comb begin
    len_cur_d = len_cur_q;
    if (rot_up) begin
      len_cur_d = len_cur_q + LW'(1);
    end else if (rot_dn) begin
      len_cur_d = len_cur_q - LW'(1);
    end
  end

  // Request handshake. A text request is shifted into the history at the
  // accepting edge and judged once the result register is free; no new request is
  // taken while that judgment is pending.
  logic eval_q, eval_d;
  logic last_q, last_d;
  logic in_acc, text_acc, load_acc;
  logic eval_done;

  assign in_stall_o = align_busy || eval_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign text_acc   = in_acc && (in_req_i.operation == soc_pkg::OP_TEXT);
  assign load_acc   = in_acc && (in_req_i.operation == soc_pkg::OP_LOAD) &&
                      (SW'(in_req_i.pattern_index) < SW'(PATTERN_MAX));

  logic          out_valid_q, out_valid_d;
  soc_pkg::res_t out_res_q, out_res_d;

  assign eval_done = eval_q && !align_busy && (!out_valid_q || !out_stall_i);

  // A load of pattern index i goes to cell (len_cur - 1 - i) mod PATTERN_MAX.
  logic [SW-1:0] load_sum, load_cell;

  assign load_sum  = SW'(len_cur_q) + SW'(PATTERN_MAX) - SW'(1) -
                     SW'(in_req_i.pattern_index);
  assign load_cell = (load_sum >= SW'(PATTERN_MAX)) ? (load_sum - SW'(PATTERN_MAX))
                                                    : load_sum;

  soc_pkg::cell_ctl_t cell_ctl;

  assign cell_ctl.shift     = text_acc;
  assign cell_ctl.clear     = eval_done && last_q;
  assign cell_ctl.rot_up    = rot_up;
  assign cell_ctl.rot_dn    = rot_dn;
  assign cell_ctl.data_byte = in_req_i.data_byte;

  // The chain: history flows from cell 0 upward, the pattern row wraps.
  logic [7:0]             hist_w [PATTERN_MAX];
  logic [7:0]             pat_w  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] valid_w;
  logic [PATTERN_MAX-1:0] ok_w;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    localparam int unsigned LO = (j == 0) ? PATTERN_MAX - 1 : j - 1;
    localparam int unsigned HI = (j == PATTERN_MAX - 1) ? 0 : j + 1;

    logic [7:0] hist_in;
    logic       valid_in;
    logic       load_sel;

    if (j == 0) begin : g_head
      assign hist_in  = in_req_i.data_byte;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign hist_in  = hist_w[j-1];
      assign valid_in = valid_w[j-1];
    end

    assign load_sel = load_acc && (load_cell == SW'(j));

    soc_cell #(
      .IDX (j),
      .LW  (LW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .load_i   (load_sel),
      .hist_i   (hist_in),
      .valid_i  (valid_in),
      .pat_lo_i (pat_w[LO]),
      .pat_hi_i (pat_w[HI]),
      .len_i    (len_cur_q),
      .hist_o   (hist_w[j]),
      .valid_o  (valid_w[j]),
      .pat_o    (pat_w[j]),
      .ok_o     (ok_w[j])
    );
  end

  // A match needs a nonzero length and every cell in the window to agree;
  // the valid bits make sure enough bytes of this text have arrived.
  logic                        hit;
  logic [soc_pkg::COUNT_W-1:0] count_q, count_d, count_next;

  assign hit        = (len_cur_q != '0) && (&ok_w);
  assign count_next = (hit && (count_q != '1)) ? (count_q + soc_pkg::COUNT_W'(1))
                                               : count_q;

  always_comb begin
    eval_d      = eval_q;
    last_d      = last_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (eval_done) begin
      eval_d                = 1'b0;
      out_valid_d           = 1'b1;
      out_res_d.match_here  = hit;
      out_res_d.match_count = count_next;
      out_res_d.final_res   = last_q;
      count_d               = last_q ? '0 : count_next;
    end
    if (text_acc) begin
      eval_d = 1'b1;
      last_d = in_req_i.end_of_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cur_q   <= LW'(soc_pkg::LEN_RESET);
      eval_q      <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_cur_q   <= len_cur_d;
      eval_q      <= eval_d;
      last_q      <= last_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  // An accepted text request always has its judgment pending in the next cycle.
  a_text_evaluates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc |=> eval_q)
    else $error("accepted text request did not start evaluation");

  // A held result keeps its payload until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // The last byte of a text restarts the running count.
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_done && last_q |=> count_q == '0)
    else $error("count not restarted after end of text");

  // While the pattern row is being realigned, no request is taken.
  a_align_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    align_busy |-> !in_acc && !eval_done)
    else $error("request handled during pattern realignment");
`endif

endmodule

[bench/testbench.sv]
// Self-checking testbench for substring_occurrence_counter_top: named tests drive
// pattern loads and text requests and compare every result with a predicted value.
// Depends on soc_pkg and the counter top level only.
`timescale 1ns / 100ps

module testbench;

  localparam int          PATTERN_MAX   = 64;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  // Cycles left to the block after the last result, before a register write or the end.
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  // The length register sits at byte address 0; bit 2 of paddr selects the register.
  localparam logic [soc_pkg::PADDR_W-1:0] LEN_ADDR = {soc_pkg::REG_PATTERN_LENGTH, 2'b00};

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  soc_pkg::req_t               in_req_i    = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  soc_pkg::res_t               out_res_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [soc_pkg::PADDR_W-1:0] paddr       = '0;
  logic [soc_pkg::PDATA_W-1:0] pwdata      = '0;
  logic [soc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  substring_occurrence_counter_top #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 20 ns clock period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Mirror of the matcher: pattern row, text history, bytes seen in the current
  // text, running occurrence count and the length register.
  logic [7:0]  pattern_copy [PATTERN_MAX];
  logic [7:0]  text_window  [PATTERN_MAX];
  int          bytes_in_text;
  logic [15:0] occurrences;
  logic [6:0]  length_reg;

  // Results owed by the block, oldest first.
  soc_pkg::res_t match_reports_due [$];

  int  mismatches    = 0;
  int  cycle_count   = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  int  rx_hold_cycles = 0;

  function automatic void note_failure(input string msg);
    if (mismatches < 10) begin
      $display("MISMATCH: %s", msg);
    end
    mismatches++;
  endfunction

  // Lengths above the row size are clipped to the row size.
  function automatic int effective_length();
    return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < PATTERN_MAX; k++) begin
      text_window[k] = 8'h00;
    end
    bytes_in_text = 0;
    occurrences   = '0;
  endfunction

  // Advances the mirror by one accepted request. A load only writes the pattern
  // row; a text byte shifts in, is judged against the tail of the history and
  // queues the result the block owes for it.
  task automatic scan_request(input soc_pkg::req_t r);
    int            n;
    bit            hit;
    soc_pkg::res_t res;
    if (r.operation == soc_pkg::OP_LOAD) begin
      pattern_copy[r.pattern_index] = r.data_byte;
      return;
    end
    for (int k = PATTERN_MAX - 1; k > 0; k--) begin
      text_window[k] = text_window[k-1];
    end
    text_window[0] = r.data_byte;
    if (bytes_in_text < PATTERN_MAX) begin
      bytes_in_text++;
    end
    n   = effective_length();
    hit = (n != 0) && (bytes_in_text >= n);
    // Pattern byte k lines up with the history entry n-1-k (entry 0 is newest).
    for (int k = 0; k < n; k++) begin
      if (pattern_copy[k] != text_window[n-1-k]) begin
        hit = 1'b0;
      end
    end
    if (hit && occurrences != COUNT_MAX) begin
      occurrences++;
    end
    res.match_here  = hit;
    res.match_count = occurrences;
    res.final_res   = r.end_of_text;
    match_reports_due.push_back(res);
    if (r.end_of_text) begin
      clear_text();
    end
  endtask

  // Offers one request, with an occasional idle burst ahead of it, and holds it
  // until the block takes it. Valid stays high from one request to the next
  // unless a burst lowers it.
  task automatic send_request(input soc_pkg::req_t r);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    scan_request(r);
  endtask

  task automatic send_text(input logic [7:0] b, input bit last);
    soc_pkg::req_t r;
    r.operation     = soc_pkg::OP_TEXT;
    r.pattern_index = soc_pkg::INDEX_W'($urandom);  // unused by text requests
    r.data_byte     = b;
    r.end_of_text   = last;
    send_request(r);
  endtask

  task automatic send_load(input logic [5:0] idx, input logic [7:0] b, input bit eot);
    soc_pkg::req_t r;
    r.operation     = soc_pkg::OP_LOAD;
    r.pattern_index = idx;
    r.data_byte     = b;
    r.end_of_text   = eot;
    send_request(r);
  endtask

  // Lowers valid at once and waits until every owed result has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (match_reports_due.size() != 0) @(posedge clk_i);
  endtask

  // Writes the length register while the block is idle and reads it back.
  task automatic set_length(input logic [6:0] len);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= soc_pkg::PDATA_W'(len);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    length_reg = len;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== soc_pkg::PDATA_W'(length_reg)) begin
      note_failure($sformatf("length readback: expected %0d, got %0h", length_reg, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads pattern entries 0..n-1 from a small alphabet, so that periodic
  // patterns and overlapping occurrences turn up often.
  task automatic reload_pattern(input int n);
    logic [7:0] alphabet [3];
    for (int a = 0; a < 3; a++) begin
      alphabet[a] = 8'($urandom);
    end
    for (int k = 0; k < n; k++) begin
      send_load(6'(k), alphabet[$urandom_range(0, 2)], 1'($urandom));
    end
  endtask

  // Sends n_items text bytes split into texts. Bytes come mostly from copies of
  // the active pattern and from pattern bytes, the rest at random; a few loads
  // to random entries are mixed in. The phase may end in the middle of a text.
  task automatic run_text_phase(input int n_items);
    int         done;
    int         eff;
    int         tl;
    int         copy_left;
    logic [7:0] b;
    done = 0;
    eff  = effective_length();
    while (done < n_items) begin
      if (eff > 8) begin
        tl = $urandom_range(eff, 3 * eff);
      end else begin
        tl = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 24);
      end
      copy_left = 0;
      for (int i = 0; i < tl && done < n_items; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_load(6'($urandom), 8'($urandom), 1'($urandom));
        end
        if (copy_left == 0 && eff > 0 && $urandom_range(0, 2) == 0) begin
          copy_left = eff;
        end
        if (copy_left > 0) begin
          b = pattern_copy[eff - copy_left];
          copy_left--;
        end else if ($urandom_range(0, 1) == 1) begin
          b = pattern_copy[$urandom_range(0, (eff > 0 ? eff : 1) - 1)];
        end else begin
          b = 8'($urandom);
        end
        send_text(b, i == tl - 1);
        done++;
      end
    end
  endtask

  // Every pattern entry gets written before any text byte is compared, so no
  // comparison ever sees an entry that was never loaded.
  task automatic test_pattern_fill();
    for (int k = 0; k < PATTERN_MAX; k++) begin
      send_load(6'(k), 8'($urandom), 1'($urandom));
    end
  endtask

  // Reset length of one: the byte extremes, a load carrying the end mark in the
  // middle of a text, and the restart after a final byte.
  task automatic test_single_byte();
    send_load(6'd0, 8'h00, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_load(6'd0, 8'hFF, 1'b1);
    send_text(8'hFF, 1'b1);
    send_text(8'hFF, 1'b1);
  endtask

  // A text shorter than the pattern, then overlapping occurrences.
  task automatic test_overlap();
    set_length(7'd3);
    send_load(6'd0, 8'h41, 1'b0);
    send_load(6'd1, 8'h42, 1'b0);
    send_load(6'd2, 8'h41, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b1);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b0);
    send_text(8'h41, 1'b1);
  endtask

  // Length zero never matches, even on bytes equal to the pattern.
  task automatic test_zero_length();
    set_length(7'd0);
    send_text(8'h41, 1'b0);
    send_text(8'h41, 1'b1);
  endtask

  // The length changes in the middle of a text; each byte is judged with the
  // length in force when it arrives, against the whole history so far.
  task automatic test_length_change();
    set_length(7'd1);
    send_text(8'h42, 1'b0);
    send_text(8'h41, 1'b0);
    set_length(7'd2);
    send_text(8'h42, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b1);
  endtask

  // A pattern of the full row size, then a length above the row size.
  task automatic test_long_pattern();
    set_length(7'd64);
    reload_pattern(PATTERN_MAX);
    run_text_phase(160);
    set_length(7'd127);
    run_text_phase(100);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // block fills up and stalls its input; then the sender waits for every result.
  task automatic test_backpressure();
    set_length(7'd2);
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_text(pattern_copy[$urandom_range(0, 1)], i == 39);
    end
    wait_drained();
  endtask

  // One long text where every byte matches, then a one-byte text: the count climbs
  // by one per byte and starts again from zero after the final byte.
  task automatic test_match_run();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_length(7'd1);
    send_load(6'd0, 8'h5A, 1'b0);
    for (int i = 0; i < 40; i++) begin
      send_text(8'h5A, i == 39);
    end
    send_text(8'h5A, 1'b1);
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Random phases: each picks a length, mostly short, sometimes zero, the row
  // size or above it, usually reloads the pattern, and streams texts.
  task automatic test_random_traffic();
    int   pick;
    logic [6:0] len;
    repeat (6) begin
      pick = $urandom_range(0, 19);
      unique case (pick)
        0: begin
          len = 7'd0;
        end
        1: begin
          len = 7'd64;
        end
        2: begin
          len = 7'd127;
        end
        3: begin
          len = 7'($urandom_range(65, 126));
        end
        4: begin
          len = 7'($urandom_range(9, 63));
        end
        default: begin
          len = 7'($urandom_range(1, 8));
        end
      endcase
      set_length(len);
      if ($urandom_range(0, 2) != 0) begin
        reload_pattern((len > PATTERN_MAX) ? PATTERN_MAX : int'(len));
      end
      run_text_phase(90);
    end
  endtask

  // Closing stretch with neither side idling.
  task automatic test_quiet_finish();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_length(7'd2);
    reload_pattern(2);
    run_text_phase(100);
    send_text(8'($urandom), 1'b1);
  endtask

  // Receiver: random stall bursts, and a long hold-off when a test asks for it.
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every accepted result is matched with the oldest owed one, field by field.
  always @(posedge clk_i) begin
    soc_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (match_reports_due.size() == 0) begin
        note_failure($sformatf("result with none owed: here=%0d count=%0d final=%0d",
                               out_res_o.match_here, out_res_o.match_count,
                               out_res_o.final_res));
      end else begin
        want = match_reports_due.pop_front();
        if (out_res_o.match_here !== want.match_here ||
            out_res_o.match_count !== want.match_count ||
            out_res_o.final_res !== want.final_res) begin
          note_failure($sformatf(
            "expected here=%0d count=%0d final=%0d, got here=%0d count=%0d final=%0d",
            want.match_here, want.match_count, want.final_res,
            out_res_o.match_here, out_res_o.match_count, out_res_o.final_res));
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pattern_copy[k] = 8'h00;
    end
    clear_text();
    length_reg = soc_pkg::LEN_RESET;
    // Reset is held low from the start and released at a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pattern_fill();
    test_single_byte();
    test_overlap();
    test_zero_length();
    test_length_change();
    test_long_pattern();
    test_backpressure();
    test_match_run();
    test_random_traffic();
    test_quiet_finish();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (match_reports_due.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", match_reports_due.size()));
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/soc_pkg.sv
design/soc_cfg.sv
design/soc_cell.sv
design/substring_occurrence_counter_top.sv
bench/testbench.sv
